// File: rtl/rfsg_pkg.sv
`timescale 1ns / 1ps
package rfsg_pkg;

  localparam int MAX_STEPS = 64;
  localparam int N_W       = $clog2(MAX_STEPS + 1);
  localparam int K_W       = $clog2(MAX_STEPS);
  localparam int DIV_BITS  = 15;                    // |diff| * 100 fits in 15 bits
  localparam int CNT_W     = $clog2(DIV_BITS);
  localparam int ACC_W     = 15;
  localparam int STP_W     = 16;
  localparam int PC_W      = 4;

  localparam logic [ACC_W-1:0] ACC_MAX     = 15'd25500;
  localparam logic [13:0]      RECIP       = 14'd10486; // ceil(2^20 / 100)
  localparam int               RECIP_SHIFT = 20;
  localparam logic [7:0]       RING_SIZE_RST = 8'd24;

  // item kinds as carried on in_tuser
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FADE  = 1'b1;

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_FADE_INIT,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_DIV_STORE,
    OP_ACC,
    OP_EMIT_FADE,
    OP_EMIT_PIX
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_PIX,
    C_N_ZERO,
    C_CNT_NZ,
    C_CH_MORE,
    C_K_MORE,
    C_DROP
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    logic  wait_out;
    pc_t   target;
  } cw_t;

  typedef struct packed {
    op_t  op;
    logic exec;
  } ctl_t;

  typedef struct packed {
    logic in_valid;
    logic is_pix;
    logic n_zero;
    logic cnt_nz;
    logic ch_more;
    logic k_more;
    logic drop;
    logic out_busy;
  } flags_t;

  // program addresses
  localparam pc_t A_IDLE   = 4'd0;
  localparam pc_t A_DISP   = 4'd1;
  localparam pc_t A_FADE   = 4'd2;
  localparam pc_t A_DLOAD  = 4'd3;
  localparam pc_t A_DITER  = 4'd4;
  localparam pc_t A_DSTORE = 4'd5;
  localparam pc_t A_EACC   = 4'd6;
  localparam pc_t A_EOUT   = 4'd7;
  localparam pc_t A_END    = 4'd8;
  localparam pc_t A_PCHK   = 4'd9;
  localparam pc_t A_POUT   = 4'd10;

  function automatic cw_t rfsg_rom(input pc_t addr);
    cw_t cw;
    case (addr)
      A_IDLE:   cw = '{OP_LOAD,      C_NO_INPUT, 1'b0, A_IDLE};
      A_DISP:   cw = '{OP_NOP,       C_PIX,      1'b0, A_PCHK};
      A_FADE:   cw = '{OP_FADE_INIT, C_N_ZERO,   1'b0, A_IDLE};
      A_DLOAD:  cw = '{OP_DIV_LOAD,  C_NEVER,    1'b0, A_IDLE};
      A_DITER:  cw = '{OP_DIV_STEP,  C_CNT_NZ,   1'b0, A_DITER};
      A_DSTORE: cw = '{OP_DIV_STORE, C_CH_MORE,  1'b0, A_DLOAD};
      A_EACC:   cw = '{OP_ACC,       C_NEVER,    1'b0, A_IDLE};
      A_EOUT:   cw = '{OP_EMIT_FADE, C_K_MORE,   1'b1, A_EACC};
      A_END:    cw = '{OP_NOP,       C_ALWAYS,   1'b0, A_IDLE};
      A_PCHK:   cw = '{OP_NOP,       C_DROP,     1'b0, A_IDLE};
      A_POUT:   cw = '{OP_EMIT_PIX,  C_ALWAYS,   1'b1, A_IDLE};
      default:  cw = '{OP_NOP,       C_ALWAYS,   1'b0, A_IDLE};
    endcase
    return cw;
  endfunction

endpackage

// File: rtl/rfsg_seq.sv
`timescale 1ns / 1ps
module rfsg_seq import rfsg_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  flags_t flags,
  output ctl_t   ctl
);

  pc_t  pc_r, pc_nxt;
  cw_t  cw;
  logic cond_true;
  logic stall;

  always_comb begin
    cw = rfsg_rom(pc_r);
    case (cw.cond)
      C_NEVER:    cond_true = 1'b0;
      C_ALWAYS:   cond_true = 1'b1;
      C_NO_INPUT: cond_true = !flags.in_valid;
      C_PIX:      cond_true = flags.is_pix;
      C_N_ZERO:   cond_true = flags.n_zero;
      C_CNT_NZ:   cond_true = flags.cnt_nz;
      C_CH_MORE:  cond_true = flags.ch_more;
      C_K_MORE:   cond_true = flags.k_more;
      C_DROP:     cond_true = flags.drop;
      default:    cond_true = 1'b0;
    endcase
  end

  assign stall    = cw.wait_out && flags.out_busy;
  assign ctl.op   = cw.op;
  assign ctl.exec = !stall;

  always_comb begin
    if (stall) begin
      pc_nxt = pc_r;
    end else if (cond_true) begin
      pc_nxt = cw.target;
    end else begin
      pc_nxt = pc_r + pc_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= A_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> $stable(pc_r))
    else $error("program counter moved during output stall");

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= A_POUT)
    else $error("program counter outside program");

endmodule

// File: rtl/rfsg_dp.sv
`timescale 1ns / 1ps
module rfsg_dp import rfsg_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  ctl_t          ctl,
  output flags_t        flags,
  input  logic          cfg_wr_en,
  input  logic [7:0]    cfg_wr_data,
  input  logic          in_tvalid,
  input  logic          in_kind,
  input  logic [7:0]    in_pixel,
  input  logic [23:0]   in_color,
  input  logic [7:0]    in_steps,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_pixel,
  output logic          out_broadcast,
  output logic [23:0]   out_color,
  output logic          out_last
);

  logic               kind_r;
  logic [7:0]         pixel_r;
  logic [23:0]        color_r;
  logic [7:0]         steps_r;
  logic [7:0]         ring_size_r;
  logic [23:0]        last_led_r;
  logic [N_W-1:0]     n_r;
  logic [K_W-1:0]     k_r;
  logic [1:0]         ch_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [N_W:0]       rem_r;
  logic [DIV_BITS-1:0] quo_r;
  logic               neg_r;
  logic signed [STP_W-1:0] stp_r [3];
  logic [ACC_W-1:0]   acc_r [3];

  logic               out_valid_r;
  logic [7:0]         out_pixel_r;
  logic               out_bcast_r;
  logic [23:0]        out_color_r;
  logic               out_last_r;

  logic [N_W-1:0]     n_sat;
  logic [7:0]         s_sel, t_sel, mag;
  logic [DIV_BITS-1:0] dvd;
  logic [N_W:0]       trial;
  logic               trial_ge;
  logic [23:0]        fade_color;
  logic [28:0]        prod [3];
  logic [ACC_W-1:0]   acc_nxt [3];
  logic signed [ACC_W+1:0] sum [3];
  logic               emit;
  logic               do_op;

  assign do_op = ctl.exec;
  assign emit  = do_op && (ctl.op == OP_EMIT_FADE || ctl.op == OP_EMIT_PIX);

  assign n_sat = (steps_r > 8'(MAX_STEPS)) ? N_W'(MAX_STEPS) : steps_r[N_W-1:0];

  // divider operand for the current channel: |t - s| * 100
  always_comb begin
    s_sel = last_led_r[ch_r*8 +: 8];
    t_sel = color_r[ch_r*8 +: 8];
    mag   = (t_sel < s_sel) ? (s_sel - t_sel) : (t_sel - s_sel);
    dvd   = {1'b0, mag, 6'b0} + {2'b0, mag, 5'b0} + {5'b0, mag, 2'b0};
    trial = {rem_r[N_W-1:0], quo_r[DIV_BITS-1]};
    trial_ge = trial >= {1'b0, n_r};
  end

  // accumulate with clamp, and scale to 8 bits by reciprocal multiply
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = $signed({2'b0, acc_r[i]}) + $signed({stp_r[i][STP_W-1], stp_r[i]});
      if (sum[i] < 0) begin
        acc_nxt[i] = '0;
      end else if (sum[i] > $signed({2'b0, ACC_MAX})) begin
        acc_nxt[i] = ACC_MAX;
      end else begin
        acc_nxt[i] = sum[i][ACC_W-1:0];
      end
      prod[i] = 29'(acc_r[i]) * 29'(RECIP);
      fade_color[i*8 +: 8] = prod[i][RECIP_SHIFT +: 8];
    end
  end

  always_comb begin
    flags.in_valid = in_tvalid;
    flags.is_pix   = (kind_r == KIND_PIXEL);
    flags.n_zero   = (steps_r == 8'd0);
    flags.cnt_nz   = (cnt_r != '0);
    flags.ch_more  = (ch_r != 2'd2);
    flags.k_more   = ({1'b0, k_r} + N_W'(1)) != n_r;
    flags.drop     = (pixel_r >= ring_size_r);
    flags.out_busy = out_valid_r && !out_ready;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_size_r <= RING_SIZE_RST;
      last_led_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        ring_size_r <= cfg_wr_data;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (do_op && ctl.op == OP_EMIT_FADE) begin
        last_led_r <= fade_color;
      end else if (do_op && ctl.op == OP_EMIT_PIX && pixel_r == ring_size_r - 8'd1) begin
        last_led_r <= color_r;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (ctl.op == OP_LOAD && in_tvalid) begin
      kind_r  <= in_kind;
      pixel_r <= in_pixel;
      color_r <= in_color;
      steps_r <= in_steps;
    end
    if (do_op) begin
      case (ctl.op)
        OP_FADE_INIT: begin
          n_r  <= n_sat;
          k_r  <= '0;
          ch_r <= 2'd0;
          for (int i = 0; i < 3; i++) begin
            acc_r[i] <= ACC_W'(last_led_r[i*8 +: 8]) * ACC_W'(100);
          end
        end
        OP_DIV_LOAD: begin
          quo_r <= dvd;
          rem_r <= '0;
          neg_r <= (t_sel < s_sel);
          cnt_r <= CNT_W'(DIV_BITS - 1);
        end
        OP_DIV_STEP: begin
          rem_r <= trial_ge ? (trial - {1'b0, n_r}) : trial;
          quo_r <= {quo_r[DIV_BITS-2:0], trial_ge};
          cnt_r <= cnt_r - CNT_W'(1);
        end
        OP_DIV_STORE: begin
          for (int i = 0; i < 3; i++) begin
            if (ch_r == 2'(i)) begin
              stp_r[i] <= neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
            end
          end
          ch_r <= ch_r + 2'd1;
        end
        OP_ACC: begin
          for (int i = 0; i < 3; i++) begin
            acc_r[i] <= acc_nxt[i];
          end
        end
        OP_EMIT_FADE: begin
          out_pixel_r <= '0;
          out_bcast_r <= 1'b1;
          out_color_r <= fade_color;
          out_last_r  <= !flags.k_more;
          k_r         <= k_r + K_W'(1);
        end
        OP_EMIT_PIX: begin
          out_pixel_r <= pixel_r;
          out_bcast_r <= 1'b0;
          out_color_r <= color_r;
          out_last_r  <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel     = out_pixel_r;
  assign out_broadcast = out_bcast_r;
  assign out_color     = out_color_r;
  assign out_last      = out_last_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.exec && (ctl.op == OP_EMIT_FADE || ctl.op == OP_EMIT_PIX))
      |-> !(out_valid_r && !out_ready))
    else $error("result written over one not yet taken");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.exec && ctl.op == OP_DIV_STORE) |-> (rem_r < {1'b0, n_r}))
    else $error("division remainder not below divisor");

endmodule

// File: rtl/rgb_fade_step_generator.sv
`timescale 1ns / 1ps
// channel   dir  tdata (low bit up)                      tuser       tlast
// in_       in   pixel[7:0] color[31:8] steps[39:32]     kind        -
// out_      out  out_pixel[7:0] out_color[31:8]          broadcast   last
// cfg_      in   cfg_wr_data = ring_size, written when cfg_wr_en
//
// set-pixel item: fetch, dispatch, ring check, then emit; a pixel past the ring is dropped
// fade item: three 15-step serial divisions of the shared restoring divider, then two
//   program steps per result; a fade of zero steps ends after its init with no result
// reset: synchronous active-low, ring_size 24, kept color black, program at idle
// a stalled output holds the program on its emit step; one result is buffered
module rgb_fade_step_generator import rfsg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,   // ring_size
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,      // pixel, color, steps
  input  logic        in_tuser,      // kind
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,     // out_pixel, out_color
  output logic        out_tuser,     // broadcast
  output logic        out_tlast      // last result of the item
);

  ctl_t   ctl;
  flags_t flags;
  logic [7:0]  res_pixel;
  logic [23:0] res_color;

  // input transfer only while the program sits at its fetch step, never in reset
  assign in_tready = (ctl.op == OP_LOAD) && rst_n;

  rfsg_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctl   (ctl)
  );

  rfsg_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .flags         (flags),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_tvalid     (in_tvalid),
    .in_kind       (in_tuser),
    .in_pixel      (in_tdata[7:0]),
    .in_color      (in_tdata[31:8]),
    .in_steps      (in_tdata[39:32]),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_pixel     (res_pixel),
    .out_broadcast (out_tuser),
    .out_color     (res_color),
    .out_last      (out_tlast)
  );

  assign out_tdata = {res_color, res_pixel};

endmodule

// File: sim/rgb_fade_step_generator_tb.sv
`timescale 1ns / 1ps
module rgb_fade_step_generator_tb import rfsg_pkg::*;;

  // one led write as it leaves the block
  typedef struct packed {
    logic [7:0]  pixel;
    logic        bcast;
    logic [23:0] color;
    logic        is_last;
  } led_write_t;

  // tracks the kept color and ring size, queues the writes each item must cause
  class fade_scoreboard;
    logic [7:0]  ring_size;
    logic [23:0] kept_color;
    led_write_t  pending_writes[$];
    int          n_items, n_fades, n_pixels, n_dropped, n_checked, n_errors;

    function new();
      ring_size  = RING_SIZE_RST;
      kept_color = '0;
    endfunction

    function void note_item(logic kind, logic [7:0] pixel, logic [23:0] color,
                            logic [7:0] steps);
      int         n;
      int         s, t, a;
      int         stp[3];
      int         acc[3];
      logic [23:0] c;
      led_write_t w;
      n_items++;
      if (kind == KIND_PIXEL) begin
        n_pixels++;
        // pixels past the ring are dropped without a write
        if ({1'b0, pixel} >= {1'b0, ring_size}) begin
          n_dropped++;
          return;
        end
        w = '{pixel, 1'b0, color, 1'b1};
        pending_writes.push_back(w);
        if (pixel == ring_size - 8'd1)
          kept_color = color;
        return;
      end
      n_fades++;
      n = (steps > MAX_STEPS) ? MAX_STEPS : steps;
      if (n == 0)
        return;
      // per-channel step in hundredths, truncated toward zero
      for (int ch = 0; ch < 3; ch++) begin
        s = kept_color[ch*8 +: 8];
        t = color[ch*8 +: 8];
        stp[ch] = ((t - s) * 100) / n;
        acc[ch] = s * 100;
      end
      for (int k = 0; k < n; k++) begin
        c = '0;
        for (int ch = 0; ch < 3; ch++) begin
          a = acc[ch] + stp[ch];
          if (a < 0)
            a = 0;
          if (a > 25500)
            a = 25500;
          acc[ch] = a;
          c[ch*8 +: 8] = 8'(a / 100);
        end
        w = '{8'd0, 1'b1, c, (k == n - 1)};
        pending_writes.push_back(w);
        kept_color = c;
      end
    endfunction

    function void check_write(led_write_t got);
      led_write_t exp;
      n_checked++;
      if (pending_writes.size() == 0) begin
        n_errors++;
        $display("%0t: result with nothing expected, expected none, got %h", $time, got);
        return;
      end
      exp = pending_writes.pop_front();
      if (got.pixel !== exp.pixel) begin
        n_errors++;
        $display("%0t: out_pixel expected %h got %h", $time, exp.pixel, got.pixel);
      end
      if (got.bcast !== exp.bcast) begin
        n_errors++;
        $display("%0t: broadcast expected %b got %b", $time, exp.bcast, got.bcast);
      end
      if (got.color !== exp.color) begin
        n_errors++;
        $display("%0t: out_color expected %h got %h", $time, exp.color, got.color);
      end
      if (got.is_last !== exp.is_last) begin
        n_errors++;
        $display("%0t: last expected %b got %b", $time, exp.is_last, got.is_last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;     // pixel, color, steps
  logic        in_tuser = 1'b0;   // kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // out_pixel, out_color
  logic        out_tuser;         // broadcast
  logic        out_tlast;         // last result of the item

  fade_scoreboard sb;
  logic quiet_mode = 1'b0;        // no idling on either side
  int   stall_left = 0;
  int   n_settings = 0;

  always #2 clk = ~clk;

  rgb_fade_step_generator u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  // receiver backpressure: random stall bursts
  always @(negedge clk) begin
    if (quiet_mode) begin
      stall_left = 0;
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // every output transfer is checked against the oldest expected write
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_write(led_write_t'{out_tdata[7:0], out_tuser, out_tdata[31:8], out_tlast});
  end

  // one input transfer; entered and left at a falling edge
  task automatic send_item(input logic kind, input logic [7:0] pixel,
                           input logic [23:0] color, input logic [7:0] steps);
    int gap;
    gap = (!quiet_mode && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {steps, color, pixel};
    do @(posedge clk); while (!in_tready);
    sb.note_item(kind, pixel, color, steps);
    @(negedge clk);
  endtask

  // hold the sender until every expected write is out, then let the block settle
  task automatic wait_idle(input int settle);
    int guard;
    guard = 0;
    in_tvalid <= 1'b0;
    while (sb.pending_writes.size() != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (settle) @(posedge clk);
    @(negedge clk);
  endtask

  // the ring size is only rewritten with the block idle
  task automatic write_ring_size(input logic [7:0] value);
    wait_idle(100);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sb.ring_size = value;
    n_settings++;
  endtask

  // mostly well-formed traffic: hits on the last led, in-range pixels, short fades
  task automatic run_random(input int count);
    int          r, lc;
    logic [7:0]  pixel, steps;
    logic [23:0] color;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2)
        wait_idle(0);  // let everything drain before going on
      lc    = sb.ring_size;
      r     = $urandom_range(0, 99);
      color = 24'($urandom);
      if ($urandom_range(0, 6) == 0)
        color = $urandom_range(0, 1) ? 24'hffffff : 24'h000000;
      if (r < 50) begin
        steps = 8'($urandom);
        if (lc > 0 && $urandom_range(0, 99) < 40)
          pixel = 8'(lc - 1);
        else if (lc > 0 && $urandom_range(0, 99) < 75)
          pixel = 8'($urandom_range(0, lc - 1));
        else
          pixel = 8'($urandom);
        send_item(KIND_PIXEL, pixel, color, steps);
      end else if (r < 85) begin
        pixel = 8'($urandom);
        r     = $urandom_range(0, 9);
        if (r < 7)
          steps = 8'($urandom_range(1, 12));
        else if (r == 7)
          steps = 8'd0;
        else if (r == 8)
          steps = 8'($urandom_range(13, MAX_STEPS));
        else
          steps = 8'($urandom_range(MAX_STEPS + 1, 255));
        send_item(KIND_FADE, pixel, color, steps);
      end else begin
        // noise: any field combination, long fades kept rare
        steps = 8'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 8));
        send_item(1'($urandom_range(0, 1)), 8'($urandom), color, steps);
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset ring size, kept color starts black
    send_item(KIND_FADE,  8'd0,   24'hffffff, 8'd0);    // zero steps, nothing out
    send_item(KIND_FADE,  8'd0,   24'hffffff, 8'd1);
    send_item(KIND_FADE,  8'd255, 24'h000000, 8'd255);  // saturates to max steps
    send_item(KIND_FADE,  8'd0,   24'h80ff01, 8'd3);
    send_item(KIND_FADE,  8'd0,   24'h123456, 8'd64);
    send_item(KIND_FADE,  8'd0,   24'hfedcba, 8'd65);
    send_item(KIND_PIXEL, 8'd0,   24'h000000, 8'd255);
    send_item(KIND_PIXEL, 8'd23,  24'habcdef, 8'd0);    // last led moves the kept color
    send_item(KIND_PIXEL, 8'd24,  24'h111111, 8'd0);    // just past the ring
    send_item(KIND_PIXEL, 8'd255, 24'hffffff, 8'd0);
    send_item(KIND_FADE,  8'd255, 24'h00ff00, 8'd7);
    send_item(KIND_PIXEL, 8'd23,  24'hffffff, 8'd0);
    send_item(KIND_FADE,  8'd0,   24'h000000, 8'd200);

    write_ring_size(8'd255);
    send_item(KIND_PIXEL, 8'd254, 24'h5a5a5a, 8'd0);
    send_item(KIND_PIXEL, 8'd255, 24'h0f0f0f, 8'd0);
    send_item(KIND_FADE,  8'd0,   24'ha5a5a5, 8'd2);

    write_ring_size(8'd1);
    send_item(KIND_PIXEL, 8'd0,   24'hc0ffee, 8'd0);
    send_item(KIND_PIXEL, 8'd1,   24'h123123, 8'd0);
    send_item(KIND_FADE,  8'd0,   24'hffffff, 8'd4);

    // empty ring: every pixel dropped, fades still run
    write_ring_size(8'd0);
    send_item(KIND_PIXEL, 8'd0,   24'h777777, 8'd0);
    send_item(KIND_FADE,  8'd0,   24'h010203, 8'd5);
    send_item(KIND_FADE,  8'd0,   24'hffffff, 8'd0);

    // random phases over several ring sizes
    write_ring_size(8'($urandom_range(2, 8)));
    run_random(68);
    write_ring_size(8'd255);
    run_random(68);
    write_ring_size(8'($urandom_range(1, 255)));
    run_random(68);
    write_ring_size(8'd1);
    run_random(68);
    write_ring_size(8'd24);
    quiet_mode = 1'b1;  // last stretch runs at full rate
    run_random(68);

    wait_idle(100);
    if (sb.pending_writes.size() != 0) begin
      sb.n_errors += sb.pending_writes.size();
      $display("%0t: %0d expected writes never came out", $time, sb.pending_writes.size());
    end
    $display("ran %0d items (%0d set-pixel, %0d dropped, %0d fades) under %0d ring size writes",
             sb.n_items, sb.n_pixels, sb.n_dropped, sb.n_fades, n_settings);
    $display("checked %0d led writes, %0d field errors", sb.n_checked, sb.n_errors);
    if (sb.n_errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("%0t: run did not finish in time", $time);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
